/* rtl/heun_polynomial_ode_step_core_assert.svh */
// Assertion macros used by the checker file of this block.
// Both macros expect signals named clk and rst_n in the scope of use.
`ifndef HEUN_POLYNOMIAL_ODE_STEP_CORE_ASSERT_SVH
`define HEUN_POLYNOMIAL_ODE_STEP_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HEUN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HEUN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/heun_pkg.sv */
package heun_pkg;

  // Fixed widths of the data path and the register file.
  localparam int DATA_W       = 32;
  localparam int STORED_TERMS = 4;
  localparam int TERM_IDX_W   = 2;
  localparam int DEG_W        = 3;
  localparam int DEG_FIELD_W  = 6;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int IN_DATA_W    = 64;
  localparam int OUT_DATA_W   = 136;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_TERMS  = 4;
  localparam int DEF_MAX_DEGREE = 7;
  localparam int DEF_FRAC_BITS  = 16;

  // Reset values of the registers that do not reset to zero.
  localparam logic [2:0]        TERM_COUNT_RESET = 3'd1;
  localparam logic signed [31:0] STEP_RESET      = 32'sd6554;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TERM_COUNT   = 3'd0,
    REG_DEGREE_TABLE = 3'd1,
    REG_COEF_LOW     = 3'd2,
    REG_COEF_HIGH    = 3'd3,
    REG_STEP_SIZE    = 3'd4
  } cfg_reg_t;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_ADD = 2'd1,
    ALU_AVG = 2'd2
  } alu_op_t;

  // Configuration as seen by the sequencer.
  typedef struct packed {
    logic [2:0]                          term_count;
    logic [STORED_TERMS*DEG_FIELD_W-1:0] degree_table;
    logic [STORED_TERMS-1:0][DATA_W-1:0] coef;
    logic signed [DATA_W-1:0]            step;
  } cfg_t;

  // One finished result.
  typedef struct packed {
    logic signed [DATA_W-1:0] k1;
    logic signed [DATA_W-1:0] k2;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic                     ov;
  } res_t;

endpackage

/* rtl/heun_alu.sv */
module heun_alu
  import heun_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  alu_op_t                  op,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic signed [DATA_W-1:0] res,
  output logic                     ov
);

  localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] LIM_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] LIM_MIN  = -64'sd2147483648;

  logic signed [63:0]     prod;
  logic signed [63:0]     prod_rnd;
  logic signed [63:0]     prod_shf;
  logic signed [DATA_W:0] sum_ext;

  // Full product, rounded half up, then scaled back to the fixed-point grid.
  assign prod     = 64'(a) * 64'(b);
  assign prod_rnd = prod + RND_HALF;
  assign prod_shf = prod_rnd >>> FRAC_BITS;

  // Exact sum with one guard bit.
  assign sum_ext = 33'(a) + 33'(b);

  // Saturate the selected result to 32 bits.
  always_comb begin
    res = '0;
    ov  = 1'b0;
    case (op)
      ALU_MUL: begin
        if (prod_shf > LIM_MAX) begin
          res = S32_MAX;
          ov  = 1'b1;
        end else if (prod_shf < LIM_MIN) begin
          res = S32_MIN;
          ov  = 1'b1;
        end else begin
          res = prod_shf[DATA_W-1:0];
        end
      end
      ALU_ADD: begin
        if (sum_ext[DATA_W] != sum_ext[DATA_W-1]) begin
          res = sum_ext[DATA_W] ? S32_MIN : S32_MAX;
          ov  = 1'b1;
        end else begin
          res = sum_ext[DATA_W-1:0];
        end
      end
      ALU_AVG: begin
        // Halving rounds toward minus infinity and always fits.
        res = sum_ext[DATA_W:1];
      end
      default: begin
        res = '0;
        ov  = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/heun_seq.sv */
module heun_seq
  import heun_pkg::*;
#(
  parameter int MAX_TERMS  = DEF_MAX_TERMS,
  parameter int MAX_DEGREE = DEF_MAX_DEGREE,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  logic                     req_kind,
  input  logic signed [DATA_W-1:0] req_x,
  input  logic signed [DATA_W-1:0] req_y,
  output logic                     res_valid,
  input  logic                     res_ready,
  output res_t                     res
);

  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(64'sd1 <<< FRAC_BITS);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_POWX  = 12'b0000_0000_0010,
    S_POWY  = 12'b0000_0000_0100,
    S_MULXY = 12'b0000_0000_1000,
    S_MULC  = 12'b0000_0001_0000,
    S_ACC   = 12'b0000_0010_0000,
    S_KMUL  = 12'b0000_0100_0000,
    S_ADDX  = 12'b0000_1000_0000,
    S_ADDY  = 12'b0001_0000_0000,
    S_AVG   = 12'b0010_0000_0000,
    S_FINAL = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } seq_state_t;

  seq_state_t state_r, state_nxt;

  logic signed [DATA_W-1:0] x_r, y_r;
  logic signed [DATA_W-1:0] ex_r, ey_r;
  logic signed [DATA_W-1:0] acc_r, px_r, sum_r;
  logic signed [DATA_W-1:0] k1_r, k2_r;
  logic                     ov_r;
  logic                     pass_r;
  logic [TERM_IDX_W-1:0]    t_r;
  logic [DEG_W-1:0]         cnt_r;

  logic [2:0]               n_eff;
  logic [DEG_FIELD_W-1:0]   deg_fld;
  logic [DEG_W-1:0]         deg_x, deg_y;
  logic                     last_term;
  logic                     powx_more, powy_more;

  alu_op_t                  alu_op;
  logic signed [DATA_W-1:0] alu_a, alu_b, alu_res;
  logic                     alu_ov;

  // Number of active terms, limited by the parameter and by the stored terms.
  always_comb begin
    n_eff = cfg.term_count;
    if (int'(n_eff) > MAX_TERMS) begin
      n_eff = 3'(MAX_TERMS);
    end
    if (int'(n_eff) > STORED_TERMS) begin
      n_eff = 3'(STORED_TERMS);
    end
  end

  // Degrees of the current term, clamped to the largest supported degree.
  assign deg_fld = cfg.degree_table[t_r*DEG_FIELD_W +: DEG_FIELD_W];

  always_comb begin
    deg_x = deg_fld[DEG_W-1:0];
    deg_y = deg_fld[DEG_FIELD_W-1:DEG_W];
    if (int'(deg_x) > MAX_DEGREE) begin
      deg_x = DEG_W'(MAX_DEGREE);
    end
    if (int'(deg_y) > MAX_DEGREE) begin
      deg_y = DEG_W'(MAX_DEGREE);
    end
  end

  assign powx_more = (cnt_r < deg_x);
  assign powy_more = (cnt_r < deg_y);
  assign last_term = ((3'({1'b0, t_r}) + 3'd1) >= n_eff);

  // Operand selection for the shared unit.
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = acc_r;
    alu_b  = ex_r;
    unique case (state_r)
      S_POWX:  begin alu_op = ALU_MUL; alu_a = acc_r; alu_b = ex_r;              end
      S_POWY:  begin alu_op = ALU_MUL; alu_a = acc_r; alu_b = ey_r;              end
      S_MULXY: begin alu_op = ALU_MUL; alu_a = acc_r; alu_b = px_r;              end
      S_MULC:  begin alu_op = ALU_MUL; alu_a = acc_r; alu_b = cfg.coef[t_r];     end
      S_ACC:   begin alu_op = ALU_ADD; alu_a = sum_r; alu_b = acc_r;             end
      S_KMUL:  begin alu_op = ALU_MUL; alu_a = sum_r; alu_b = cfg.step;          end
      S_ADDX:  begin alu_op = ALU_ADD; alu_a = x_r;   alu_b = cfg.step;          end
      S_ADDY:  begin alu_op = ALU_ADD; alu_a = y_r;   alu_b = k1_r;              end
      S_AVG:   begin alu_op = ALU_AVG; alu_a = k1_r;  alu_b = k2_r;              end
      S_FINAL: begin alu_op = ALU_ADD; alu_a = y_r;   alu_b = acc_r;             end
      default: begin alu_op = ALU_ADD; alu_a = acc_r; alu_b = ex_r;              end
    endcase
  end

  heun_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .ov  (alu_ov)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          if (!req_kind) begin
            state_nxt = S_DONE;
          end else if (n_eff == 3'd0) begin
            state_nxt = S_KMUL;
          end else begin
            state_nxt = S_POWX;
          end
        end
      end
      S_POWX:  state_nxt = powx_more ? S_POWX : S_POWY;
      S_POWY:  state_nxt = powy_more ? S_POWY : S_MULXY;
      S_MULXY: state_nxt = S_MULC;
      S_MULC:  state_nxt = S_ACC;
      S_ACC:   state_nxt = last_term ? S_KMUL : S_POWX;
      S_KMUL:  state_nxt = pass_r ? S_AVG : S_ADDX;
      S_ADDX:  state_nxt = S_ADDY;
      S_ADDY:  state_nxt = (n_eff == 3'd0) ? S_KMUL : S_POWX;
      S_AVG:   state_nxt = S_FINAL;
      S_FINAL: state_nxt = S_DONE;
      S_DONE:  state_nxt = res_ready ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Current point: cleared by reset, set by a load, advanced at the end of a step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else if (state_r == S_IDLE && req_valid && !req_kind) begin
      x_r <= req_x;
      y_r <= req_y;
    end else if (state_r == S_FINAL) begin
      x_r <= ex_r;
      y_r <= alu_res;
    end
  end

  // Working registers of the two slope evaluations.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          ov_r <= 1'b0;
          if (!req_kind) begin
            k1_r <= '0;
            k2_r <= '0;
          end else begin
            ex_r   <= x_r;
            ey_r   <= y_r;
            sum_r  <= '0;
            t_r    <= '0;
            cnt_r  <= '0;
            acc_r  <= ONE;
            pass_r <= 1'b0;
          end
        end
      end
      S_POWX: begin
        if (powx_more) begin
          acc_r <= alu_res;
          cnt_r <= cnt_r + 1'b1;
          ov_r  <= ov_r | alu_ov;
        end else begin
          // x power is done; start the y power from one.
          px_r  <= acc_r;
          acc_r <= ONE;
          cnt_r <= '0;
        end
      end
      S_POWY: begin
        if (powy_more) begin
          acc_r <= alu_res;
          cnt_r <= cnt_r + 1'b1;
          ov_r  <= ov_r | alu_ov;
        end
      end
      S_MULXY, S_MULC: begin
        acc_r <= alu_res;
        ov_r  <= ov_r | alu_ov;
      end
      S_ACC: begin
        sum_r <= alu_res;
        ov_r  <= ov_r | alu_ov;
        t_r   <= t_r + 1'b1;
        acc_r <= ONE;
        cnt_r <= '0;
      end
      S_KMUL: begin
        if (pass_r) begin
          k2_r <= alu_res;
        end else begin
          k1_r <= alu_res;
        end
        ov_r <= ov_r | alu_ov;
      end
      S_ADDX: begin
        ex_r <= alu_res;
        ov_r <= ov_r | alu_ov;
      end
      S_ADDY: begin
        // Second evaluation at (x+h, y+k1).
        ey_r   <= alu_res;
        ov_r   <= ov_r | alu_ov;
        sum_r  <= '0;
        t_r    <= '0;
        cnt_r  <= '0;
        acc_r  <= ONE;
        pass_r <= 1'b1;
      end
      S_AVG: begin
        acc_r <= alu_res;
      end
      S_FINAL: begin
        ov_r <= ov_r | alu_ov;
      end
      default: begin
      end
    endcase
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.k1    = k1_r;
  assign res.k2    = k2_r;
  assign res.x     = x_r;
  assign res.y     = y_r;
  assign res.ov    = ov_r;

endmodule

/* rtl/heun_polynomial_ode_step_core.sv */
// Heun (second-order Runge-Kutta) step engine for dy/dx = sum of c*x^a*y^b over up
// to four terms, in signed fixed point with FRAC_BITS fraction bits (Q16.16 by
// default). A request with in_tuser 0 loads the point (start_x, start_y) and returns
// it with zero slopes; a request with in_tuser 1 computes k1 = h*f(x,y) and
// k2 = h*f(x+h, y+k1), moves to (x+h, y+(k1+k2)/2) and returns slopes and point,
// with the overflow bit set when any intermediate value saturated. All arithmetic
// runs through one shared 32x32 multiply/add unit, one operation per cycle, so the
// block takes one request at a time. The result passes through an output register
// and may wait there while the next request is already being worked on.
// Configuration is to be written only while no request is in progress; the block
// itself does not enforce this.
module heun_polynomial_ode_step_core
  import heun_pkg::*;
#(
  parameter int MAX_TERMS  = DEF_MAX_TERMS,
  parameter int MAX_DEGREE = DEF_MAX_DEGREE,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // start_x[31:0], start_y[63:32]
  input  logic [0:0]            in_tuser,   // kind[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // slope_k1, slope_k2, x_now, y_now,
                                            // overflow[128], zero pad[135:129]
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                     cfg_r;
  logic                     seq_res_valid;
  logic                     seq_res_ready;
  res_t                     seq_res;
  logic                     out_valid_r;
  res_t                     out_res_r;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.term_count   <= TERM_COUNT_RESET;
      cfg_r.degree_table <= '0;
      cfg_r.coef         <= '0;
      cfg_r.step         <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TERM_COUNT:   cfg_r.term_count   <= cfg_wdata[2:0];
        REG_DEGREE_TABLE: cfg_r.degree_table <= cfg_wdata[STORED_TERMS*DEG_FIELD_W-1:0];
        REG_COEF_LOW:     cfg_r.coef[1:0]    <= cfg_wdata;
        REG_COEF_HIGH:    cfg_r.coef[3:2]    <= cfg_wdata;
        REG_STEP_SIZE:    cfg_r.step         <= cfg_wdata[DATA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  heun_seq #(
    .MAX_TERMS  (MAX_TERMS),
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_kind  (in_tuser[0]),
    .req_x     (in_tdata[DATA_W-1:0]),
    .req_y     (in_tdata[2*DATA_W-1:DATA_W]),
    .res_valid (seq_res_valid),
    .res_ready (seq_res_ready),
    .res       (seq_res)
  );

  // Output register: frees the sequencer while a result waits downstream.
  assign seq_res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_res_ready) begin
      out_valid_r <= seq_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_res_ready && seq_res_valid) begin
      out_res_r <= seq_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.ov, out_res_r.y, out_res_r.x,
                       out_res_r.k2, out_res_r.k1};

endmodule

/* rtl/heun_chk.sv */
`include "heun_polynomial_ode_step_core_assert.svh"

module heun_chk
  import heun_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic [0:0]            in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  cfg_we,
  input logic [CFG_ADDR_W-1:0] cfg_addr,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic cfg_seen;

  assign cfg_seen = cfg_we && (cfg_addr != '0 || cfg_wdata != '0);

  // A stalled result holds.
  `HEUN_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // A step request keeps the block busy in the following cycle.
  `HEUN_ASSERT_NXT(a_step_busy, in_tvalid && in_tready && in_tuser[0], !in_tready, "step request did not occupy the sequencer")

  // A load into an empty output returns the loaded point with zero slopes, no overflow.
  `HEUN_ASSERT_IMP(a_load_echo, in_tvalid && in_tready && !in_tuser[0] && !out_tvalid && !cfg_seen, ##2 (out_tvalid && out_tdata[63:0] == '0 && !out_tdata[128] && out_tdata[127:64] == $past(in_tdata, 2)), "load result does not match the loaded point")

  // Pad bits above the overflow flag stay zero.
  `HEUN_ASSERT_IMP(a_pad_zero, out_tvalid, out_tdata[135:129] == '0, "nonzero pad bits in result")

endmodule

bind heun_polynomial_ode_step_core heun_chk u_heun_chk (.*);

/* tb/heun_polynomial_ode_step_core_tb.sv */
module heun_polynomial_ode_step_core_tb;
  import heun_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC        = DEF_FRAC_BITS;
  localparam int ITEM_TARGET = 1950;
  localparam int CALM_FROM   = ITEM_TARGET - 250;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 200;

  // Request kinds carried on in_tuser.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // Register indexes that the block has no register for.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic                     kind;
    logic signed [DATA_W-1:0] sx;
    logic signed [DATA_W-1:0] sy;
  } ode_req_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // start_x[31:0], start_y[63:32]
  logic [0:0]            in_tuser   = '0;  // kind[0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // slope_k1, slope_k2, x_now, y_now, overflow[128]
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  heun_polynomial_ode_step_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Shadow copy of the register file and of the current point.
  logic [2:0]               tc_reg    = TERM_COUNT_RESET;
  logic [23:0]              deg_reg   = '0;
  logic [63:0]              coef_lo   = '0;
  logic [63:0]              coef_hi   = '0;
  logic signed [DATA_W-1:0] step_h    = STEP_RESET;
  logic signed [DATA_W-1:0] pt_x      = '0;
  logic signed [DATA_W-1:0] pt_y      = '0;

  ode_req_t ode_req_q[$];
  res_t     heun_results_q[$];
  ode_req_t cur_req;

  bit calm      = 1'b0;
  int send_gap  = 0;
  int sink_gap  = 0;
  int quiet     = 0;
  int n_queued  = 0;
  int n_loads   = 0;
  int n_steps   = 0;
  int n_checked = 0;
  int n_sat     = 0;
  int n_setups  = 0;
  int n_errors  = 0;

  // Clamp a wide value to 32 bits and note any saturation.
  function automatic logic signed [DATA_W-1:0] clamp_s32(input longint v, inout bit sat);
    if (v > longint'(S32_MAX)) begin
      sat = 1'b1;
      return S32_MAX;
    end
    if (v < longint'(S32_MIN)) begin
      sat = 1'b1;
      return S32_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_add32(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b,
                                                        inout bit sat);
    return clamp_s32(longint'(a) + longint'(b), sat);
  endfunction

  // Exact product, round half up, then clamp.
  function automatic logic signed [DATA_W-1:0] qmul(input logic signed [DATA_W-1:0] a,
                                                   input logic signed [DATA_W-1:0] b,
                                                   inout bit sat);
    longint p;
    p = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC - 1));
    return clamp_s32(p >>> FRAC, sat);
  endfunction

  function automatic logic signed [DATA_W-1:0] qpow(input logic signed [DATA_W-1:0] base,
                                                   input int deg, inout bit sat);
    logic signed [DATA_W-1:0] acc;
    int d;
    acc = 32'sd1 <<< FRAC;
    d = (deg > DEF_MAX_DEGREE) ? DEF_MAX_DEGREE : deg;
    repeat (d) acc = qmul(acc, base, sat);
    return acc;
  endfunction

  // Sum of c * x^a * y^b over the active terms.
  function automatic logic signed [DATA_W-1:0] poly_eval(input logic signed [DATA_W-1:0] x,
                                                        input logic signed [DATA_W-1:0] y,
                                                        inout bit sat);
    int n;
    int t;
    logic [5:0] fld;
    logic [63:0] cw;
    logic signed [DATA_W-1:0] sum, px, py, c;
    n = int'(tc_reg);
    if (n > DEF_MAX_TERMS) n = DEF_MAX_TERMS;
    if (n > STORED_TERMS) n = STORED_TERMS;
    sum = '0;
    for (t = 0; t < n; t++) begin
      fld = deg_reg[6*t +: 6];
      cw  = (t < 2) ? coef_lo : coef_hi;
      c   = t[0] ? cw[63:32] : cw[31:0];
      px  = qpow(x, int'(fld[2:0]), sat);
      py  = qpow(y, int'(fld[5:3]), sat);
      sum = sat_add32(sum, qmul(qmul(py, px, sat), c, sat), sat);
    end
    return sum;
  endfunction

  // Apply one accepted request to the shadow point and queue its result.
  task automatic heun_advance(input ode_req_t rq);
    res_t r;
    bit sat;
    logic signed [DATA_W-1:0] k1, k2, x2, y2;
    longint ksum;
    sat = 1'b0;
    k1  = '0;
    k2  = '0;
    if (rq.kind == KIND_LOAD) begin
      pt_x = rq.sx;
      pt_y = rq.sy;
    end else begin
      k1   = qmul(poly_eval(pt_x, pt_y, sat), step_h, sat);
      x2   = sat_add32(pt_x, step_h, sat);
      y2   = sat_add32(pt_y, k1, sat);
      k2   = qmul(step_h, poly_eval(x2, y2, sat), sat);
      pt_x = x2;
      // The average of the slopes rounds toward minus infinity.
      ksum = longint'(k1) + longint'(k2);
      pt_y = clamp_s32(longint'(pt_y) + (ksum >>> 1), sat);
    end
    r.k1 = k1;
    r.k2 = k2;
    r.x  = pt_x;
    r.y  = pt_y;
    r.ov = sat;
    heun_results_q.push_back(r);
  endtask

  // Random Q16.16 value: mostly moderate, sometimes full range or an extreme.
  function automatic logic signed [DATA_W-1:0] rand_q16();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return int'($urandom_range(0, 262144)) - 131072;
      4, 5:       return int'($urandom_range(0, 8388608)) - 4194304;
      6:          return $urandom;
      7:          return int'($urandom_range(0, 8)) * 16384 - 65536;
      default: begin
        case ($urandom_range(0, 4))
          0:       return S32_MAX;
          1:       return S32_MIN;
          2:       return 32'sd65536;
          3:       return -32'sd65536;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic void push_req(input logic kind, input logic signed [DATA_W-1:0] x,
                                   input logic signed [DATA_W-1:0] y);
    ode_req_t rq;
    rq.kind = kind;
    rq.sx   = x;
    rq.sy   = y;
    ode_req_q.push_back(rq);
    n_queued++;
    if (kind == KIND_LOAD) n_loads++;
    else n_steps++;
  endfunction

  // Register writes happen only while the block is idle, so the shadow copy
  // can follow the write at once.
  task automatic reg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_TERM_COUNT:   tc_reg  = val[2:0];
      REG_DEGREE_TABLE: deg_reg = val[23:0];
      REG_COEF_LOW:     coef_lo = val;
      REG_COEF_HIGH:    coef_hi = val;
      REG_STEP_SIZE:    step_h  = val[31:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold off until every queued request has gone out and every result is back.
  task automatic wait_idle();
    do @(negedge clk);
    while (ode_req_q.size() != 0 || in_tvalid || heun_results_q.size() != 0);
    repeat (4) @(negedge clk);
    n_setups++;
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        heun_advance(cur_req);
        if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 5);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (ode_req_q.size() > 0) begin
        cur_req = ode_req_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {cur_req.sy, cur_req.sx};
        in_tuser  <= cur_req.kind;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic signed [DATA_W-1:0] want,
                             input logic signed [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Result monitor with random backpressure.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (heun_results_q.size() == 0) begin
          $error("result with no request outstanding: %h", out_tdata);
          n_errors++;
        end else begin
          want = heun_results_q.pop_front();
          check_field("slope_k1", want.k1, out_tdata[31:0]);
          check_field("slope_k2", want.k2, out_tdata[63:32]);
          check_field("x_now", want.x, out_tdata[95:64]);
          check_field("y_now", want.y, out_tdata[127:96]);
          check_field("overflow", {31'b0, want.ov}, {31'b0, out_tdata[128]});
          check_field("pad", '0, {25'b0, out_tdata[135:129]});
          n_checked++;
          if (want.ov) n_sat++;
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) sink_gap = $urandom_range(1, 5);
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL heun_polynomial_ode_step_core");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    bit wild;
    int len;
    int left;
    int t;
    logic [CFG_DATA_W-1:0] w;
    logic [23:0] deg_pick;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setup: f is zero, so only x moves; then steps from both extreme corners, x saturating at the top.
    push_req(KIND_LOAD, '0, '0);
    push_req(KIND_STEP, $urandom, $urandom);
    push_req(KIND_LOAD, S32_MAX, S32_MIN);
    push_req(KIND_STEP, $urandom, $urandom);
    push_req(KIND_LOAD, S32_MIN, S32_MAX);
    push_req(KIND_STEP, $urandom, $urandom);
    wait_idle();

    // Four low-degree terms, a constant term among them, h = 0.25.
    reg_write(REG_TERM_COUNT, 64'd4);
    reg_write(REG_DEGREE_TABLE, {40'd0, 6'b000_000, 6'b001_010, 6'b001_000, 6'b000_001});
    reg_write(REG_COEF_LOW, {32'shFFFF_8000, 32'sh0001_0000});
    reg_write(REG_COEF_HIGH, {32'sh0002_0000, 32'sh0000_4000});
    reg_write(REG_STEP_SIZE, 64'd16384);
    push_req(KIND_LOAD, 32'sh0001_0000, -32'sh0001_0000);
    repeat (3) push_req(KIND_STEP, $urandom, $urandom);
    push_req(KIND_LOAD, '0, '0);
    push_req(KIND_STEP, $urandom, $urandom);
    wait_idle();

    // No terms at all, with the most negative step.
    reg_write(REG_TERM_COUNT, 64'd0);
    reg_write(REG_STEP_SIZE, {32'hFFFF_FFFF, S32_MIN});
    push_req(KIND_LOAD, 32'sh0003_0000, 32'sh0002_0000);
    push_req(KIND_STEP, $urandom, $urandom);
    wait_idle();

    // Term count above the limit, top degrees, extreme coefficients and step,
    // plus writes to indexes with no register behind them.
    reg_write(REG_TERM_COUNT, 64'd7);
    reg_write(REG_DEGREE_TABLE, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_write(REG_COEF_LOW, {S32_MAX, S32_MAX});
    reg_write(REG_COEF_HIGH, {32'sh0001_0000, S32_MIN});
    reg_write(REG_STEP_SIZE, {32'd0, S32_MAX});
    for (w = 64'(REG_SPARE_LO); w <= 64'(REG_SPARE_HI); w++)
      reg_write(w[2:0], {$urandom, $urandom});
    push_req(KIND_LOAD, 32'sh0002_0000, -32'sh0002_0000);
    push_req(KIND_STEP, $urandom, $urandom);
    push_req(KIND_STEP, $urandom, $urandom);
    push_req(KIND_LOAD, -32'sh0001_0000, 32'sh0000_8000);
    push_req(KIND_STEP, $urandom, $urandom);
    wait_idle();

    // Random setups, each followed by trajectories: a load and a run of steps.
    while (n_queued < ITEM_TARGET) begin
      if (n_queued >= CALM_FROM) calm = 1'b1;
      wild = ($urandom_range(0, 6) == 0);

      w = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0:       w[2:0] = 3'd0;
        1:       w[2:0] = 3'($urandom_range(5, 7));
        default: w[2:0] = 3'($urandom_range(1, 4));
      endcase
      reg_write(REG_TERM_COUNT, w);

      if (wild) begin
        deg_pick = 24'($urandom);
      end else begin
        for (t = 0; t < STORED_TERMS; t++) begin
          if ($urandom_range(0, 7) == 0) deg_pick[6*t +: 6] = 6'($urandom);
          else deg_pick[6*t +: 6] = {3'($urandom_range(0, 2)), 3'($urandom_range(0, 2))};
        end
      end
      reg_write(REG_DEGREE_TABLE, {$urandom, 8'($urandom), deg_pick});
      reg_write(REG_COEF_LOW, wild ? {$urandom, $urandom} : {rand_q16(), rand_q16()});
      reg_write(REG_COEF_HIGH, wild ? {$urandom, $urandom} : {rand_q16(), rand_q16()});

      w = {$urandom, $urandom};
      if (wild) begin
        case ($urandom_range(0, 2))
          0:       w[31:0] = S32_MAX;
          1:       w[31:0] = S32_MIN;
          default: w[31:0] = '0;
        endcase
      end else if ($urandom_range(0, 9) == 0) begin
        w[31:0] = rand_q16();
      end else begin
        w[31:0] = int'($urandom_range(0, 32768)) - 16384;
      end
      reg_write(REG_STEP_SIZE, w);

      if ($urandom_range(0, 3) == 0)
        reg_write(3'(REG_SPARE_LO + $urandom_range(0, 2)), {$urandom, $urandom});

      left = $urandom_range(20, 60);
      while (left > 0) begin
        // Now and then a run continues from the previous point with no load.
        if ($urandom_range(0, 5) != 0) begin
          push_req(KIND_LOAD, rand_q16(), rand_q16());
          left--;
        end
        len = $urandom_range(1, 10);
        repeat (len) begin
          if (left > 0) begin
            push_req(KIND_STEP, $urandom, $urandom);
            left--;
          end
        end
      end
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d loads, %0d steps) over %0d register setups.",
             n_queued, n_loads, n_steps, n_setups);
    $display("Checked %0d results, %0d of them with saturation flagged.", n_checked, n_sat);
    if (n_errors == 0) begin
      $display("PASS heun_polynomial_ode_step_core");
    end else begin
      $display("FAIL heun_polynomial_ode_step_core");
    end
    $finish;
  end

endmodule
